FILE: design/tbsi_pkg.sv
// Package for the time-to-byte seek index: status codes, register indexes,
// register reset values and the request type of the shared arithmetic unit.
// No dependencies.
`default_nettype none

package tbsi_pkg;

  localparam int StatusW = 3;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 16;
  localparam int SegOutW = 6;

  typedef enum logic [StatusW-1:0] {
    ST_APPENDED    = 3'd0,
    ST_NEW_SEGMENT = 3'd1,
    ST_DROPPED     = 3'd2,
    ST_FULL        = 3'd3,
    ST_FOUND       = 3'd4,
    ST_EXTRAP      = 3'd5,
    ST_NO_INDEX    = 3'd6
  } status_e;

  localparam logic [CfgIdxW-1:0] REG_RATIO_DEN   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MIN_GAP     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_PACKET_SIZE = 2'd2;

  localparam logic [CfgW-1:0] RATIO_DEN_RESET   = 16'd100;
  localparam logic [CfgW-1:0] MIN_GAP_RESET     = 16'd3;
  localparam logic [CfgW-1:0] PACKET_SIZE_RESET = 16'd188;

  typedef enum logic {
    MDU_MUL = 1'b0,
    MDU_DIV = 1'b1
  } mdu_op_e;

  typedef struct packed {
    logic    start;
    mdu_op_e op;
  } mdu_req_t;

endpackage

`default_nettype wire

FILE: design/tbsi_if.sv
// Valid/ready channel interfaces for the seek index: input items and results.
// Depends on tbsi_pkg for field widths.
`default_nettype none

interface tbsi_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] sample_time;
  logic [63:0] sample_bytes;
  logic [63:0] query_time;

  modport source (output valid, func, sample_time, sample_bytes, query_time, input ready);
  modport sink (input valid, func, sample_time, sample_bytes, query_time, output ready);
endinterface

interface tbsi_out_if;
  logic                         valid;
  logic                         ready;
  logic [tbsi_pkg::StatusW-1:0] status;
  logic [63:0]                  byte_position;
  logic [tbsi_pkg::SegOutW-1:0] segment_number;

  modport source (output valid, status, byte_position, segment_number, input ready);
  modport sink (input valid, status, byte_position, segment_number, output ready);
endinterface

`default_nettype wire

FILE: design/time_to_byte_seek_index.sv
// Time-to-byte seek index top level: sample and segment stores, sequencer
// and result register. Depends on tbsi_pkg, tbsi_if.sv and tbsi_mdu.
//
// Items arrive on item_i (valid/ready); func 0 appends a (time, size) sample,
// func 1 looks up a byte offset for query_time. Every item gives one result
// on result_o. Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i.
// One item is worked on at a time; item_i.ready is high only between items.
// An append reads the last sample and the open segment's start; when the rate
// test runs it adds three multiplies in the shared unit. A lookup scans the
// segments in turn, then binary-searches within the segment found;
// extrapolation adds a divide, a multiply and an alignment divide in the
// shared unit. Reset empties the index and loads the register defaults; the
// sample stores need no clearing pass. A finished result waits in an output
// register, so the next item is accepted while the receiver stalls; that
// item then waits in its last step until the register frees up.
`default_nettype none

module time_to_byte_seek_index #(
  parameter int TABLE_DEPTH  = 4096,
  parameter int MAX_SEGMENTS = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [tbsi_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [tbsi_pkg::CfgW-1:0]    cfg_data_i,
  tbsi_in_if.sink                           item_i,
  tbsi_out_if.source                        result_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int KW = SW + 1;
  localparam logic [CW-1:0] DepthC  = CW'(TABLE_DEPTH);
  localparam logic [KW-1:0] MaxSegC = KW'(MAX_SEGMENTS);

  typedef enum logic [23:0] {
    S_IDLE   = 24'h000001,
    S_A_RD1  = 24'h000002,
    S_A_RD2  = 24'h000004,
    S_A_RD3  = 24'h000008,
    S_A_MUL1 = 24'h000010,
    S_A_MUL2 = 24'h000020,
    S_A_MUL3 = 24'h000040,
    S_A_WR   = 24'h000080,
    S_L_SEG0 = 24'h000100,
    S_L_SEG1 = 24'h000200,
    S_L_SEG2 = 24'h000400,
    S_L_T1   = 24'h000800,
    S_L_T2   = 24'h001000,
    S_L_T3   = 24'h002000,
    S_L_BS   = 24'h004000,
    S_L_BS2  = 24'h008000,
    S_L_BF1  = 24'h010000,
    S_L_BF2  = 24'h020000,
    S_X_DIV  = 24'h040000,
    S_X_PREP = 24'h080000,
    S_X_MUL  = 24'h100000,
    S_X_SAT  = 24'h200000,
    S_X_MOD  = 24'h400000,
    S_FIN    = 24'h800000
  } state_e;

  state_e state_q, state_d;

  // Index state and registers.
  logic [CW-1:0]             sample_cnt_q;
  logic [KW-1:0]             seg_cnt_q;
  logic [63:0]               closed_t_q;
  logic [63:0]               closed_s_q;
  logic [tbsi_pkg::CfgW-1:0] den_q;
  logic [tbsi_pkg::CfgW-1:0] gap_q;
  logic [tbsi_pkg::CfgW-1:0] pkt_q;

  // Stores.
  logic [63:0]   time_mem [TABLE_DEPTH];
  logic [63:0]   size_mem [TABLE_DEPTH];
  logic [AW-1:0] seg_mem  [MAX_SEGMENTS];
  logic [AW-1:0] rd_addr;
  logic [SW-1:0] seg_rd_addr;
  logic [63:0]   tdata_q;
  logic [63:0]   sdata_q;
  logic [AW-1:0] segdata_q;
  logic          mem_we;

  // Working registers.
  logic [63:0]  t_q, b_q;
  logic [63:0]  dt_q, dv_q, seg_dt_q, seg_sz_q, ssum_q;
  logic [143:0] lhs_q;
  logic         new_seg_q;
  logic [SW-1:0] k_q;
  logic          last_q;
  logic [AW-1:0] i0_q, i1_q, j0_q, j1_q, j_q;
  logic [63:0]  t0_q, t1_q, p0_q, p1_q, rate_q, p_q;
  logic [127:0] prod_q;

  // Pending result and output register.
  tbsi_pkg::status_e            res_status_q;
  logic [63:0]                  res_pos_q;
  logic [tbsi_pkg::SegOutW-1:0] res_seg_q;
  logic                         out_valid_q;
  tbsi_pkg::status_e            out_status_q;
  logic [63:0]                  out_pos_q;
  logic [tbsi_pkg::SegOutW-1:0] out_seg_q;

  // Shared unit.
  tbsi_pkg::mdu_req_t mdu_req;
  logic [127:0]       mdu_a;
  logic [63:0]        mdu_b;
  logic               mdu_done;
  logic [191:0]       mdu_res;

  tbsi_mdu u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mdu_req),
    .a_i    (mdu_a),
    .b_i    (mdu_b),
    .done_o (mdu_done),
    .res_o  (mdu_res)
  );

  logic                         accept;
  logic                         out_free;
  logic [AW-1:0]                last_idx;
  logic [SW-1:0]                cur_seg;
  logic [tbsi_pkg::SegOutW-1:0] cur_seg_out;
  logic [63:0]                  dt_w, dv_w, tsum_w, ssum_w;
  logic                         below_w;
  logic                         found_w;
  logic                         more_w;
  logic [AW-1:0]                mid_w;
  logic                         up_w;
  logic [63:0]                  diff_w;
  logic [64:0]                  sum_w;
  logic [63:0]                  sat_w;

  always_comb begin
    accept      = item_i.valid && item_i.ready;
    out_free    = !out_valid_q || result_o.ready;
    last_idx    = AW'(sample_cnt_q - CW'(1));
    cur_seg     = SW'(seg_cnt_q - KW'(1));
    cur_seg_out = (seg_cnt_q == '0) ? '0 : tbsi_pkg::SegOutW'(cur_seg);
    dt_w        = t_q - tdata_q;
    dv_w        = b_q - sdata_q;
    tsum_w      = closed_t_q + dt_w;
    ssum_w      = closed_s_q + dv_w;
    below_w     = lhs_q < {16'd0, mdu_res[127:0]};
    found_w     = (tdata_q != t0_q) && (t_q <= tdata_q);
    more_w      = ({1'b0, j0_q} + CW'(1)) < {1'b0, j1_q};
    mid_w       = AW'(({1'b0, j0_q} + {1'b0, j1_q}) >> 1);
    up_w        = t_q >= t1_q;
    diff_w      = up_w ? (t_q - t1_q) : (t1_q - t_q);
    sum_w       = {1'b0, p1_q} + {1'b0, prod_q[63:0]};
    if (up_w) begin
      sat_w = ((prod_q[127:64] != '0) || sum_w[64]) ? '1 : sum_w[63:0];
    end else begin
      sat_w = (prod_q > {64'd0, p1_q}) ? '0 : (p1_q - prod_q[63:0]);
    end
  end

  // Sequencer.
  always_comb begin
    state_d       = state_q;
    mdu_req.start = 1'b0;
    mdu_req.op    = tbsi_pkg::MDU_MUL;
    mdu_a         = '0;
    mdu_b         = '0;
    rd_addr       = '0;
    seg_rd_addr   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!item_i.func) begin
            if (sample_cnt_q == DepthC) begin
              state_d = S_FIN;
            end else if (seg_cnt_q == '0) begin
              state_d = S_A_WR;
            end else begin
              state_d = S_A_RD1;
            end
          end else if (seg_cnt_q == '0) begin
            state_d = S_FIN;
          end else begin
            state_d = S_L_SEG0;
          end
        end
      end
      S_A_RD1: begin
        rd_addr     = last_idx;
        seg_rd_addr = cur_seg;
        state_d     = S_A_RD2;
      end
      S_A_RD2: begin
        rd_addr = segdata_q;
        state_d = (dt_w == '0) ? S_FIN : S_A_RD3;
      end
      S_A_RD3: begin
        if ((ssum_w != '0) && (dt_q > {48'd0, gap_q})) begin
          mdu_req.start = 1'b1;
          mdu_a         = {64'd0, dv_q};
          mdu_b         = tsum_w;
          state_d       = S_A_MUL1;
        end else begin
          state_d = S_A_WR;
        end
      end
      S_A_MUL1: begin
        if (mdu_done) begin
          mdu_req.start = 1'b1;
          mdu_a         = mdu_res[127:0];
          mdu_b         = {48'd0, den_q};
          state_d       = S_A_MUL2;
        end
      end
      S_A_MUL2: begin
        if (mdu_done) begin
          mdu_req.start = 1'b1;
          mdu_a         = {64'd0, ssum_q};
          mdu_b         = dt_q;
          state_d       = S_A_MUL3;
        end
      end
      S_A_MUL3: begin
        if (mdu_done) begin
          state_d = (below_w && (seg_cnt_q == MaxSegC)) ? S_FIN : S_A_WR;
        end
      end
      S_A_WR: state_d = S_FIN;
      S_L_SEG0: begin
        seg_rd_addr = k_q;
        state_d     = S_L_SEG1;
      end
      S_L_SEG1: begin
        seg_rd_addr = k_q + SW'(1);
        state_d     = S_L_SEG2;
      end
      S_L_SEG2: begin
        rd_addr = i0_q;
        state_d = S_L_T1;
      end
      S_L_T1: begin
        rd_addr = i1_q;
        state_d = S_L_T2;
      end
      // Hold the read of the segment's last sample for the test step.
      S_L_T2: begin
        rd_addr = i1_q;
        state_d = S_L_T3;
      end
      S_L_T3: begin
        if (found_w) begin
          state_d = S_L_BS;
        end else if (!last_q) begin
          state_d = S_L_SEG0;
        end else if ((i1_q > i0_q) && (tdata_q != t0_q)) begin
          mdu_req.start = 1'b1;
          mdu_req.op    = tbsi_pkg::MDU_DIV;
          mdu_a         = {64'd0, sdata_q - p0_q};
          mdu_b         = tdata_q - t0_q;
          state_d       = S_X_DIV;
        end else begin
          state_d = S_X_PREP;
        end
      end
      S_X_DIV: begin
        if (mdu_done) begin
          state_d = S_X_PREP;
        end
      end
      S_X_PREP: begin
        mdu_req.start = 1'b1;
        mdu_a         = {64'd0, diff_w};
        mdu_b         = rate_q;
        state_d       = S_X_MUL;
      end
      S_X_MUL: begin
        if (mdu_done) begin
          state_d = S_X_SAT;
        end
      end
      S_X_SAT: begin
        if (pkt_q != '0) begin
          mdu_req.start = 1'b1;
          mdu_req.op    = tbsi_pkg::MDU_DIV;
          mdu_a         = {64'd0, sat_w};
          mdu_b         = {48'd0, pkt_q};
          state_d       = S_X_MOD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_X_MOD: begin
        if (mdu_done) begin
          state_d = S_FIN;
        end
      end
      S_L_BS: begin
        if (more_w) begin
          rd_addr = mid_w;
          state_d = S_L_BS2;
        end else begin
          rd_addr = j1_q;
          state_d = S_L_BF1;
        end
      end
      S_L_BS2: state_d = S_L_BS;
      S_L_BF1: begin
        if (t_q == tdata_q) begin
          state_d = S_FIN;
        end else begin
          rd_addr = j0_q;
          state_d = S_L_BF2;
        end
      end
      S_L_BF2: state_d = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sample_cnt_q <= '0;
      seg_cnt_q    <= '0;
      closed_t_q   <= '0;
      closed_s_q   <= '0;
      den_q        <= tbsi_pkg::RATIO_DEN_RESET;
      gap_q        <= tbsi_pkg::MIN_GAP_RESET;
      pkt_q        <= tbsi_pkg::PACKET_SIZE_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tbsi_pkg::REG_RATIO_DEN:   den_q <= cfg_data_i;
          tbsi_pkg::REG_MIN_GAP:     gap_q <= cfg_data_i;
          tbsi_pkg::REG_PACKET_SIZE: pkt_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_A_WR) begin
        sample_cnt_q <= sample_cnt_q + CW'(1);
        if (new_seg_q) begin
          seg_cnt_q  <= seg_cnt_q + KW'(1);
          closed_t_q <= closed_t_q + seg_dt_q;
          closed_s_q <= closed_s_q + seg_sz_q;
        end
      end
      if ((state_q == S_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stores with registered reads.
  assign mem_we = (state_q == S_A_WR);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      time_mem[sample_cnt_q[AW-1:0]] <= t_q;
      size_mem[sample_cnt_q[AW-1:0]] <= b_q;
      if (new_seg_q) begin
        seg_mem[SW'(seg_cnt_q)] <= sample_cnt_q[AW-1:0];
      end
    end
    tdata_q   <= time_mem[rd_addr];
    sdata_q   <= size_mem[rd_addr];
    segdata_q <= seg_mem[seg_rd_addr];
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        t_q       <= item_i.func ? item_i.query_time : item_i.sample_time;
        b_q       <= item_i.sample_bytes;
        k_q       <= '0;
        seg_dt_q  <= '0;
        seg_sz_q  <= '0;
        new_seg_q <= 1'b1;
        res_pos_q <= '0;
        if (!item_i.func) begin
          res_status_q <= tbsi_pkg::ST_FULL;
          res_seg_q    <= cur_seg_out;
        end else begin
          res_status_q <= tbsi_pkg::ST_NO_INDEX;
          res_seg_q    <= '0;
        end
      end
      S_A_RD2: begin
        dt_q         <= dt_w;
        dv_q         <= dv_w;
        res_status_q <= tbsi_pkg::ST_DROPPED;
        res_seg_q    <= cur_seg_out;
      end
      S_A_RD3: begin
        seg_dt_q  <= dt_w;
        seg_sz_q  <= dv_w;
        ssum_q    <= ssum_w;
        new_seg_q <= 1'b0;
      end
      S_A_MUL2: begin
        if (mdu_done) begin
          lhs_q <= mdu_res[143:0];
        end
      end
      S_A_MUL3: begin
        if (mdu_done) begin
          new_seg_q    <= below_w;
          res_status_q <= tbsi_pkg::ST_FULL;
          res_seg_q    <= cur_seg_out;
        end
      end
      S_A_WR: begin
        if (new_seg_q) begin
          res_status_q <= tbsi_pkg::ST_NEW_SEGMENT;
          res_seg_q    <= tbsi_pkg::SegOutW'(seg_cnt_q);
        end else begin
          res_status_q <= tbsi_pkg::ST_APPENDED;
          res_seg_q    <= cur_seg_out;
        end
      end
      S_L_SEG1: begin
        i0_q   <= segdata_q;
        last_q <= (({1'b0, k_q} + KW'(1)) == seg_cnt_q);
      end
      S_L_SEG2: begin
        i1_q <= last_q ? last_idx : (segdata_q - AW'(1));
      end
      S_L_T1: begin
        t0_q <= tdata_q;
        p0_q <= sdata_q;
      end
      S_L_T3: begin
        t1_q   <= tdata_q;
        p1_q   <= sdata_q;
        j0_q   <= i0_q;
        j1_q   <= i1_q;
        rate_q <= '0;
        if (!found_w && !last_q) begin
          k_q <= k_q + SW'(1);
        end
      end
      S_X_DIV: begin
        if (mdu_done) begin
          rate_q <= mdu_res[63:0];
        end
      end
      S_X_MUL: begin
        if (mdu_done) begin
          prod_q <= mdu_res[127:0];
        end
      end
      S_X_SAT: begin
        p_q          <= sat_w;
        res_pos_q    <= sat_w;
        res_status_q <= tbsi_pkg::ST_EXTRAP;
        res_seg_q    <= tbsi_pkg::SegOutW'(k_q);
      end
      S_X_MOD: begin
        if (mdu_done) begin
          res_pos_q <= p_q - mdu_res[127:64];
        end
      end
      S_L_BS: begin
        j_q <= mid_w;
      end
      S_L_BS2: begin
        if (t_q <= tdata_q) begin
          j1_q <= j_q;
        end else begin
          j0_q <= j_q;
        end
      end
      S_L_BF1: begin
        res_pos_q    <= sdata_q;
        res_status_q <= tbsi_pkg::ST_FOUND;
        res_seg_q    <= tbsi_pkg::SegOutW'(k_q);
      end
      S_L_BF2: begin
        res_pos_q <= sdata_q;
      end
      S_FIN: begin
        if (out_free) begin
          out_status_q <= res_status_q;
          out_pos_q    <= res_pos_q;
          out_seg_q    <= res_seg_q;
        end
      end
      default: ;
    endcase
  end

  assign item_i.ready            = (state_q == S_IDLE);
  assign result_o.valid          = out_valid_q;
  assign result_o.status         = out_status_q;
  assign result_o.byte_position  = out_pos_q;
  assign result_o.segment_number = out_seg_q;

  // An accepted item always starts a sequence of work.
  a_accept_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("accepted item did not start work");

  // The index only grows.
  a_count_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> sample_cnt_q >= $past(sample_cnt_q))
    else $error("sample count went down");

  // Segments exist exactly when samples exist, and never beyond the limit.
  a_seg_consistent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((seg_cnt_q == '0) == (sample_cnt_q == '0)) && (seg_cnt_q <= MaxSegC))
    else $error("segment count inconsistent with sample count");

  // The shared unit only finishes while the sequencer waits for it.
  a_mdu_done_waited : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdu_done |-> (state_q == S_A_MUL1 || state_q == S_A_MUL2 || state_q == S_A_MUL3 ||
                  state_q == S_X_DIV || state_q == S_X_MUL || state_q == S_X_MOD))
    else $error("arithmetic unit finished outside a wait state");

endmodule

`default_nettype wire

FILE: design/tbsi_mdu.sv
// Shared bit-serial multiply/divide unit: 128x64 shift-add multiply or
// 64/64 restoring divide, one bit per cycle. Depends on tbsi_pkg.
`default_nettype none

module tbsi_mdu (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tbsi_pkg::mdu_req_t req_i,
  input  wire logic [127:0]       a_i,
  input  wire logic [63:0]        b_i,
  output logic                    done_o,
  output logic [191:0]            res_o
);

  logic                busy_q;
  logic [5:0]          cnt_q;
  logic                done_q;
  tbsi_pkg::mdu_op_e   op_q;
  logic [127:0]        a_q;
  logic [63:0]         b_q;
  logic [191:0]        acc_q;
  logic [191:0]        acc_d;
  logic [128:0]        mul_sum;
  logic [64:0]         div_r2;
  logic                div_ge;
  logic [64:0]         div_rem;

  // Multiply: the low word of the accumulator holds the multiplier and shifts
  // out one bit a cycle while the partial sum enters from the top.
  always_comb begin
    mul_sum = {1'b0, acc_q[191:64]} + (acc_q[0] ? {1'b0, a_q} : 129'd0);
    div_r2  = {acc_q[127:64], acc_q[63]};
    div_ge  = div_r2 >= {1'b0, b_q};
    div_rem = div_ge ? (div_r2 - {1'b0, b_q}) : div_r2;
    if (op_q == tbsi_pkg::MDU_MUL) begin
      acc_d = {mul_sum, acc_q[63:1]};
    end else begin
      acc_d = {64'd0, div_rem[63:0], acc_q[62:0], div_ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd63;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q <= req_i.op;
      a_q  <= a_i;
      b_q  <= b_i;
      if (req_i.op == tbsi_pkg::MDU_MUL) begin
        acc_q <= {128'd0, b_i};
      end else begin
        acc_q <= {128'd0, a_i[63:0]};
      end
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

`default_nettype wire
